FILE: src/msps_pkg.sv
// shared constants, types and helpers for the servo pulse sequencer
package msps_pkg;

    // block sizing
    localparam int SERVO_SLOTS      = 12;
    localparam int BANK_SLOTS       = 6;
    localparam int COUNTS_PER_US    = 2;
    localparam int GAP_US           = 500;
    localparam int DEFAULT_PULSE_US = 1500;

    // fixed field widths
    localparam int ACTION_W  = 2;
    localparam int LINE_ID_W = 4;
    localparam int ANGLE_W   = 16;
    localparam int CNT_W     = 16;
    localparam int LEVELS_W  = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // derived widths
    localparam int SLOT_W  = $clog2(SERVO_SLOTS);
    localparam int USED_W  = $clog2(SERVO_SLOTS + 1);
    localparam int BSLOT_W = $clog2(BANK_SLOTS + 1);
    localparam int TIDX_W  = $clog2(2 * BANK_SLOTS + 1);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // angle to pulse divider
    localparam int PROD_W    = 2 * CNT_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // saturate a count to the counter width
    function automatic logic [CNT_W-1:0] sat_counts(input logic [PROD_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v > PROD_W'({CNT_W{1'b1}})) begin
            r = {CNT_W{1'b1}};
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

    localparam logic [CNT_W-1:0] DEFAULT_COUNTS =
        sat_counts(PROD_W'(DEFAULT_PULSE_US * COUNTS_PER_US));
    localparam logic [CNT_W-1:0] GAP_COUNTS = sat_counts(PROD_W'(GAP_US * COUNTS_PER_US));

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_MIN_ANGLE   = 16'd0;
    localparam logic [CFG_W-1:0] RST_MAX_ANGLE   = 16'd180;
    localparam logic [CFG_W-1:0] RST_USABLE_MIN  = 16'd0;
    localparam logic [CFG_W-1:0] RST_USABLE_MAX  = 16'd180;
    localparam logic [CFG_W-1:0] RST_MIN_PULSE   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_MAX_PULSE   = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE  = 3'd0,
        CFG_MAX_ANGLE  = 3'd1,
        CFG_USABLE_MIN = 3'd2,
        CFG_USABLE_MAX = 3'd3,
        CFG_MIN_PULSE  = 3'd4,
        CFG_MAX_PULSE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_ON   = 2'd2,
        ACT_OFF  = 2'd3
    } t_action;

    // classified command as it sits in the queue
    typedef struct packed {
        t_action                     action;
        logic                        line_ok;
        logic [SLOT_W-1:0]           line;
        logic signed [ANGLE_W-1:0]   angle;
    } t_cmd;

endpackage

FILE: src/msps_front.sv
// command front end: classifies items and holds them in a short queue
module msps_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [msps_pkg::ACTION_W-1:0]         i_action,
    input  logic [msps_pkg::LINE_ID_W-1:0]        i_line_id,
    input  logic signed [msps_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                  o_busy,
    input  logic                                  i_pop,
    output logic                                  o_q_valid,
    output msps_pkg::t_cmd                        o_head
);

    msps_pkg::t_cmd                    r_q [msps_pkg::Q_DEPTH];
    logic [msps_pkg::Q_PTR_W-1:0]      r_wp;
    logic [msps_pkg::Q_PTR_W-1:0]      r_rp;
    logic [msps_pkg::Q_CNT_W-1:0]      r_cnt;
    msps_pkg::t_cmd                    cmd;
    logic                              push;
    logic                              pop;

    // classify the incoming item
    always_comb begin
        cmd.action  = msps_pkg::t_action'(i_action);
        cmd.line_ok = int'(i_line_id) < msps_pkg::SERVO_SLOTS;
        cmd.line    = msps_pkg::SLOT_W'(i_line_id);
        cmd.angle   = i_angle;
    end

    assign o_busy    = (int'(r_cnt) == msps_pkg::Q_DEPTH);
    assign o_q_valid = (r_cnt != '0);
    assign o_head    = r_q[r_rp];
    assign push      = i_start && !o_busy;
    assign pop       = i_pop && o_q_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (int'(r_wp) == msps_pkg::Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (int'(r_rp) == msps_pkg::Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/msps_back.sv
// command back end: bank sequencing, slot table walks and angle mapping
module msps_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [msps_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                  i_q_valid,
    input  msps_pkg::t_cmd                        i_head,
    output logic                                  o_pop,
    output logic                                  o_done,
    output logic [msps_pkg::LEVELS_W-1:0]         o_line_levels,
    output logic                                  o_accepted,
    output logic [msps_pkg::USED_W-1:0]           o_active_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BANK,
        S_BANK2,
        S_FIND,
        S_SHIFT,
        S_MUL,
        S_DIV,
        S_PULSE,
        S_END
    } t_state;

    localparam int SW = msps_pkg::SLOT_W;
    localparam int CW = msps_pkg::CNT_W;
    localparam int PW = msps_pkg::PROD_W;
    localparam int AW = msps_pkg::ANGLE_W;

    t_state                              r_state;
    // configuration
    logic signed [AW-1:0]                r_min_ang;
    logic signed [AW-1:0]                r_max_ang;
    logic signed [AW-1:0]                r_umin;
    logic signed [AW-1:0]                r_umax;
    logic [CW-1:0]                       r_min_p;
    logic [CW-1:0]                       r_max_p;
    // sequencer state
    logic [CW-1:0]                       r_tick;
    logic [CW-1:0]                       r_cmp   [2];
    logic [msps_pkg::BSLOT_W-1:0]        r_slot  [2];
    logic                                r_phase [2];
    logic [SW-1:0]                       r_lines [msps_pkg::SERVO_SLOTS];
    logic [msps_pkg::USED_W-1:0]         r_used;
    logic [CW-1:0]                       r_pcnt  [msps_pkg::SERVO_SLOTS];
    logic [msps_pkg::SERVO_SLOTS-1:0]    r_lvl;
    // per-item working registers
    msps_pkg::t_cmd                      r_cmd;
    logic                                r_in_lim;
    logic                                r_bank;
    logic [msps_pkg::USED_W-1:0]         r_idx;
    logic [SW-1:0]                       r_line;
    logic [PW-1:0]                       r_quo;
    logic [CW-1:0]                       r_rem;
    logic                                r_neg;
    logic [msps_pkg::DIV_CNT_W-1:0]      r_dcnt;
    // result registers
    logic                                r_done;
    logic                                r_acc;
    logic [msps_pkg::LEVELS_W-1:0]       r_out_lvl;
    logic [msps_pkg::USED_W-1:0]         r_out_cnt;

    logic                                in_lim;
    logic [msps_pkg::TIDX_W-1:0]         bank_idx;
    logic                                bank_skip;
    logic [SW-1:0]                       rd_addr;
    logic [SW-1:0]                       rd_data;
    logic                                lines_we;
    logic [SW-1:0]                       lines_wa;
    logic [SW-1:0]                       lines_wd;
    logic                                at_end;
    logic                                shift_more;
    logic [AW:0]                         a_off17;
    logic [AW:0]                         den17;
    logic [CW-1:0]                       a_off;
    logic [CW-1:0]                       den;
    logic [CW-1:0]                       dp;
    logic [PW-1:0]                       prod;
    logic [CW:0]                         trial;
    logic                                trial_ge;
    logic [CW:0]                         pulse17;
    logic [CW-1:0]                       counts;
    logic [msps_pkg::LEVELS_W-1:0]       lvl_view;

    // angle limit check on the queue head
    assign in_lim = (i_head.angle >= r_min_ang) && (i_head.angle <= r_max_ang) &&
                    (i_head.angle >= r_umin) && (i_head.angle <= r_umax);

    // current bank's table index and end-of-bank test
    always_comb begin
        if (r_bank) begin
            bank_idx = msps_pkg::TIDX_W'(msps_pkg::BANK_SLOTS) +
                       msps_pkg::TIDX_W'(r_slot[1]);
        end else begin
            bank_idx = msps_pkg::TIDX_W'(r_slot[0]);
        end
        bank_skip = (int'(r_slot[r_bank]) >= msps_pkg::BANK_SLOTS) ||
                    (int'(bank_idx) >= int'(r_used)) ||
                    (int'(bank_idx) >= msps_pkg::SERVO_SLOTS);
    end

    assign at_end     = (r_idx == r_used);
    assign shift_more = (int'(r_idx) + 1 < int'(r_used));

    // single read port into the slot table
    always_comb begin
        unique case (r_state)
            S_BANK:  rd_addr = SW'(bank_idx);
            S_FIND:  rd_addr = SW'(r_idx);
            S_SHIFT: rd_addr = SW'(r_idx + 1'b1);
            default: rd_addr = '0;
        endcase
    end
    assign rd_data = r_lines[rd_addr];

    // slot table write: append or compaction move
    always_comb begin
        lines_we = 1'b0;
        lines_wa = SW'(r_used);
        lines_wd = r_line;
        priority if (r_state == S_FIND && at_end && r_cmd.action == msps_pkg::ACT_ON &&
                     !r_in_lim) begin
            lines_we = 1'b1;
        end else if (r_state == S_PULSE && r_cmd.action == msps_pkg::ACT_ON) begin
            lines_we = 1'b1;
        end else if (r_state == S_SHIFT && shift_more) begin
            lines_we = 1'b1;
            lines_wa = SW'(r_idx);
            lines_wd = rd_data;
        end else begin
            lines_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lines_we) begin
            r_lines[lines_wa] <= lines_wd;
        end
    end

    // mapping arithmetic: offset, spans, divider step, saturation
    always_comb begin
        a_off17  = {r_cmd.angle[AW-1], r_cmd.angle} - {r_min_ang[AW-1], r_min_ang};
        den17    = {r_max_ang[AW-1], r_max_ang} - {r_min_ang[AW-1], r_min_ang};
        a_off    = a_off17[CW-1:0];
        den      = den17[CW-1:0];
        dp       = (r_max_p >= r_min_p) ? (r_max_p - r_min_p) : (r_min_p - r_max_p);
        prod     = PW'(a_off) * PW'(dp);
        trial    = {r_rem, r_quo[PW-1]};
        trial_ge = (trial >= {1'b0, den});
        if (r_neg) begin
            pulse17 = {1'b0, r_min_p} - {1'b0, r_quo[CW-1:0]};
        end else begin
            pulse17 = {1'b0, r_min_p} + {1'b0, r_quo[CW-1:0]};
        end
        counts = msps_pkg::sat_counts(PW'(pulse17[CW-1:0]) * PW'(msps_pkg::COUNTS_PER_US));
    end

    // line levels as seen on the result port
    always_comb begin
        lvl_view = '0;
        for (int i = 0; i < msps_pkg::LEVELS_W; i++) begin
            if (i < msps_pkg::SERVO_SLOTS) begin
                lvl_view[i] = r_lvl[i];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ang <= msps_pkg::RST_MIN_ANGLE;
            r_max_ang <= msps_pkg::RST_MAX_ANGLE;
            r_umin    <= msps_pkg::RST_USABLE_MIN;
            r_umax    <= msps_pkg::RST_USABLE_MAX;
            r_min_p   <= msps_pkg::RST_MIN_PULSE;
            r_max_p   <= msps_pkg::RST_MAX_PULSE;
        end else if (i_cfg_we) begin
            unique case (msps_pkg::t_cfg_idx'(i_cfg_idx))
                msps_pkg::CFG_MIN_ANGLE:  r_min_ang <= i_cfg_wdata;
                msps_pkg::CFG_MAX_ANGLE:  r_max_ang <= i_cfg_wdata;
                msps_pkg::CFG_USABLE_MIN: r_umin    <= i_cfg_wdata;
                msps_pkg::CFG_USABLE_MAX: r_umax    <= i_cfg_wdata;
                msps_pkg::CFG_MIN_PULSE:  r_min_p   <= i_cfg_wdata;
                msps_pkg::CFG_MAX_PULSE:  r_max_p   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_pop = (r_state == S_IDLE) && i_q_valid;

    // sequencer state machine and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_cmp[0]  <= '0;
            r_cmp[1]  <= '0;
            r_slot[0] <= '0;
            r_slot[1] <= '0;
            r_phase[0] <= 1'b0;
            r_phase[1] <= 1'b0;
            r_used    <= '0;
            r_lvl     <= '0;
            for (int i = 0; i < msps_pkg::SERVO_SLOTS; i++) begin
                r_pcnt[i] <= msps_pkg::DEFAULT_COUNTS;
            end
            r_done    <= 1'b0;
            r_acc     <= 1'b0;
            r_out_lvl <= '0;
            r_out_cnt <= '0;
            r_bank    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd    <= i_head;
                        r_in_lim <= in_lim;
                        r_line   <= i_head.line;
                        r_idx    <= '0;
                        r_bank   <= 1'b0;
                        unique case (i_head.action)
                            msps_pkg::ACT_TICK: r_state <= S_BANK;
                            msps_pkg::ACT_SET: begin
                                if (i_head.line_ok && in_lim) begin
                                    r_state <= S_MUL;
                                end else begin
                                    r_acc   <= 1'b0;
                                    r_state <= S_END;
                                end
                            end
                            msps_pkg::ACT_ON: begin
                                if (i_head.line_ok && int'(r_used) < msps_pkg::SERVO_SLOTS) begin
                                    r_state <= S_FIND;
                                end else begin
                                    r_acc   <= 1'b0;
                                    r_state <= S_END;
                                end
                            end
                            msps_pkg::ACT_OFF: begin
                                if (i_head.line_ok) begin
                                    r_state <= S_FIND;
                                end else begin
                                    r_acc   <= 1'b0;
                                    r_state <= S_END;
                                end
                            end
                            default: r_state <= S_END;
                        endcase
                    end
                end
                S_BANK: begin
                    if (r_tick == r_cmp[r_bank] && !bank_skip) begin
                        r_line  <= rd_data;
                        r_state <= S_BANK2;
                    end else begin
                        if (r_tick == r_cmp[r_bank]) begin
                            r_cmp[r_bank]  <= '0;
                            r_slot[r_bank] <= '0;
                        end
                        if (r_bank) begin
                            r_acc   <= 1'b1;
                            r_state <= S_END;
                        end else begin
                            r_bank  <= 1'b1;
                        end
                    end
                end
                S_BANK2: begin
                    r_phase[r_bank] <= !r_phase[r_bank];
                    if (!r_phase[r_bank]) begin
                        r_lvl[r_line] <= 1'b1;
                        r_cmp[r_bank] <= r_tick + r_pcnt[r_line];
                    end else begin
                        r_lvl[r_line]  <= 1'b0;
                        r_slot[r_bank] <= r_slot[r_bank] + 1'b1;
                        r_cmp[r_bank]  <= r_tick + msps_pkg::GAP_COUNTS;
                    end
                    if (r_bank) begin
                        r_acc   <= 1'b1;
                        r_state <= S_END;
                    end else begin
                        r_bank  <= 1'b1;
                        r_state <= S_BANK;
                    end
                end
                S_FIND: begin
                    if (at_end) begin
                        if (r_cmd.action == msps_pkg::ACT_ON) begin
                            if (r_in_lim) begin
                                r_state <= S_MUL;
                            end else begin
                                r_used  <= r_used + 1'b1;
                                r_acc   <= 1'b1;
                                r_state <= S_END;
                            end
                        end else begin
                            r_acc   <= 1'b0;
                            r_state <= S_END;
                        end
                    end else if (rd_data == r_line) begin
                        if (r_cmd.action == msps_pkg::ACT_ON) begin
                            r_acc   <= 1'b0;
                            r_state <= S_END;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (shift_more) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_used  <= r_used - 1'b1;
                        r_acc   <= 1'b1;
                        r_state <= S_END;
                    end
                end
                S_MUL: begin
                    r_neg <= (r_max_p < r_min_p);
                    r_rem <= '0;
                    r_dcnt <= '0;
                    if (r_max_ang == r_min_ang) begin
                        r_quo   <= '0;
                        r_state <= S_PULSE;
                    end else begin
                        r_quo   <= prod;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_rem  <= trial_ge ? CW'(trial - {1'b0, den}) : trial[CW-1:0];
                    r_quo  <= {r_quo[PW-2:0], trial_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (int'(r_dcnt) == PW - 1) begin
                        r_state <= S_PULSE;
                    end
                end
                S_PULSE: begin
                    r_pcnt[r_line] <= counts;
                    if (r_cmd.action == msps_pkg::ACT_ON) begin
                        r_used <= r_used + 1'b1;
                    end
                    r_acc   <= 1'b1;
                    r_state <= S_END;
                end
                S_END: begin
                    if (r_cmd.action == msps_pkg::ACT_TICK) begin
                        r_tick <= r_tick + 1'b1;
                    end
                    r_done    <= 1'b1;
                    r_out_lvl <= lvl_view;
                    r_out_cnt <= r_used;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_accepted     = r_acc;
    assign o_line_levels  = r_out_lvl;
    assign o_active_count = r_out_cnt;

endmodule

FILE: src/multiplexed_servo_pulse_sequencer_core.sv
// top level of the multiplexed servo pulse sequencer
//
// Usage: an item (tick, set angle, activate, deactivate) is taken on a rising
// edge where i_start is high and o_busy is low. Each item gives exactly one
// result: o_done is high for one cycle with o_line_levels, o_accepted and
// o_active_count valid; the receiver cannot stall, so it must take it then.
// A two-entry queue sits between the command front end and the back end,
// so new items are taken while the back end is still working; o_busy rises
// only when that queue is full.
// From accept to o_done, a tick makes two bank checks, each with an optional
// update step, plus the result step; commands rejected up front (bad line,
// angle limits, full table) go straight to the result; activate/deactivate
// walk the slot table one entry a cycle; an angle mapping adds the 32-step
// restoring divider in the back end, unless the angle span is zero. The back
// end works one item at a time.
// The user must write configuration through i_cfg_we/i_cfg_idx/i_cfg_wdata only
// while idle; the block itself does not enforce this. Indexes past the last register are ignored.
// Reset (i_rst_n low, synchronous) empties the queue, clears the counter,
// both banks, the slot table count and the line levels, restores the
// calibration defaults and sets every line to the default pulse.
module multiplexed_servo_pulse_sequencer_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [msps_pkg::ACTION_W-1:0]         i_action,
    input  logic [msps_pkg::LINE_ID_W-1:0]        i_line_id,
    input  logic signed [msps_pkg::ANGLE_W-1:0]   i_angle,
    input  logic                                  i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [msps_pkg::CFG_W-1:0]            i_cfg_wdata,
    output logic                                  o_done,
    output logic [msps_pkg::LEVELS_W-1:0]         o_line_levels,
    output logic                                  o_accepted,
    output logic [msps_pkg::USED_W-1:0]           o_active_count
);

    logic            pop;
    logic            q_valid;
    msps_pkg::t_cmd  head;

    // front end: classify and queue
    msps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_action  (i_action),
        .i_line_id (i_line_id),
        .i_angle   (i_angle),
        .o_busy    (o_busy),
        .i_pop     (pop),
        .o_q_valid (q_valid),
        .o_head    (head)
    );

    // back end: execute one item at a time
    msps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_valid      (q_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_done         (o_done),
        .o_line_levels  (o_line_levels),
        .o_accepted     (o_accepted),
        .o_active_count (o_active_count)
    );

endmodule

FILE: src/msps_checker.sv
// port-level checks for the servo pulse sequencer, bound to the top level
module msps_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  o_busy,
    input  logic                                  o_done,
    input  logic [msps_pkg::LEVELS_W-1:0]         o_line_levels,
    input  logic                                  o_accepted,
    input  logic [msps_pkg::USED_W-1:0]           o_active_count
);

    // queue only fills after an item was taken
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without an accepted item");

    // slot table never holds more lines than exist
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (int'(o_active_count) <= msps_pkg::SERVO_SLOTS))
        else $error("active count out of range");

    // line levels and active count only move together with the strobe
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_done && $past(i_rst_n)) |-> ($stable(o_line_levels) && $stable(o_active_count)))
        else $error("result changed without strobe");

    // no result strobe right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("strobe right after reset");

endmodule

bind multiplexed_servo_pulse_sequencer_core msps_checker u_msps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_line_levels  (o_line_levels),
    .o_accepted     (o_accepted),
    .o_active_count (o_active_count)
);

FILE: test/tb.sv
// self-checking testbench for the multiplexed servo pulse sequencer core
module tb;

    typedef struct packed {
        logic [msps_pkg::LEVELS_W-1:0] levels;
        logic                          accepted;
        logic [msps_pkg::USED_W-1:0]   count;
    } t_servo_result;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_start;
    logic                                  o_busy;
    logic [msps_pkg::ACTION_W-1:0]         i_action;
    logic [msps_pkg::LINE_ID_W-1:0]        i_line_id;
    logic signed [msps_pkg::ANGLE_W-1:0]   i_angle;
    logic                                  i_cfg_we;
    logic [msps_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [msps_pkg::CFG_W-1:0]            i_cfg_wdata;
    logic                                  o_done;
    logic [msps_pkg::LEVELS_W-1:0]         o_line_levels;
    logic                                  o_accepted;
    logic [msps_pkg::USED_W-1:0]           o_active_count;

    multiplexed_servo_pulse_sequencer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_line_id      (i_line_id),
        .i_angle        (i_angle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_line_levels  (o_line_levels),
        .o_accepted     (o_accepted),
        .o_active_count (o_active_count)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predicted sequencer state
    logic [msps_pkg::CFG_W-1:0]    cal_regs [6];
    logic [msps_pkg::CNT_W-1:0]    tick_count;
    logic [msps_pkg::CNT_W-1:0]    bank_compare [2];
    logic [2:0]                    bank_slot [2];
    logic                          bank_high [2];
    logic [3:0]                    table_lines [msps_pkg::SERVO_SLOTS];
    int unsigned                   table_used;
    logic [msps_pkg::CNT_W-1:0]    pulse_counts [msps_pkg::SERVO_SLOTS];
    logic [msps_pkg::LEVELS_W-1:0] line_levels;

    t_servo_result pending_results [$];
    int unsigned   err_count;
    int unsigned   items_sent;
    int unsigned   results_seen;
    int unsigned   cycle_count;
    bit            no_idle;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic void reset_model();
        cal_regs[msps_pkg::CFG_MIN_ANGLE]  = msps_pkg::RST_MIN_ANGLE;
        cal_regs[msps_pkg::CFG_MAX_ANGLE]  = msps_pkg::RST_MAX_ANGLE;
        cal_regs[msps_pkg::CFG_USABLE_MIN] = msps_pkg::RST_USABLE_MIN;
        cal_regs[msps_pkg::CFG_USABLE_MAX] = msps_pkg::RST_USABLE_MAX;
        cal_regs[msps_pkg::CFG_MIN_PULSE]  = msps_pkg::RST_MIN_PULSE;
        cal_regs[msps_pkg::CFG_MAX_PULSE]  = msps_pkg::RST_MAX_PULSE;
        tick_count = '0;
        for (int b = 0; b < 2; b++) begin
            bank_compare[b] = '0;
            bank_slot[b]    = '0;
            bank_high[b]    = 1'b0;
        end
        table_used  = 0;
        line_levels = '0;
        for (int i = 0; i < msps_pkg::SERVO_SLOTS; i++) begin
            table_lines[i]  = '0;
            pulse_counts[i] = 16'(msps_pkg::DEFAULT_PULSE_US * msps_pkg::COUNTS_PER_US);
        end
    endfunction

    function automatic logic [msps_pkg::CNT_W-1:0] us_counts(input longint us);
        longint c;
        c = us * msps_pkg::COUNTS_PER_US;
        return (c > 65535) ? 16'hFFFF : 16'(c);
    endfunction

    // one compare match on a bank: raise, or lower and step on, or rewind past its end
    function automatic void service_bank(input int b);
        int unsigned idx;
        logic [3:0]  ln;
        idx = b * msps_pkg::BANK_SLOTS + bank_slot[b];
        if (bank_slot[b] >= msps_pkg::BANK_SLOTS || idx >= table_used) begin
            bank_compare[b] = '0;
            bank_slot[b]    = '0;
        end else begin
            ln = table_lines[idx];
            bank_high[b] = !bank_high[b];
            if (bank_high[b]) begin
                line_levels[ln] = 1'b1;
                bank_compare[b] = tick_count + pulse_counts[ln];
            end else begin
                line_levels[ln] = 1'b0;
                bank_slot[b]    = bank_slot[b] + 3'd1;
                bank_compare[b] = tick_count + us_counts(msps_pkg::GAP_US);
            end
        end
    endfunction

    // linear angle to pulse mapping with limit checks
    function automatic bit map_angle(input int unsigned ln, input logic signed [15:0] ang);
        longint mina, maxa, umin, umax, minp, maxp, a, pulse;
        mina  = $signed(cal_regs[msps_pkg::CFG_MIN_ANGLE]);
        maxa  = $signed(cal_regs[msps_pkg::CFG_MAX_ANGLE]);
        umin  = $signed(cal_regs[msps_pkg::CFG_USABLE_MIN]);
        umax  = $signed(cal_regs[msps_pkg::CFG_USABLE_MAX]);
        minp  = cal_regs[msps_pkg::CFG_MIN_PULSE];
        maxp  = cal_regs[msps_pkg::CFG_MAX_PULSE];
        a     = ang;
        if (ln >= msps_pkg::SERVO_SLOTS) return 1'b0;
        if (a > maxa || a < mina || a > umax || a < umin) return 1'b0;
        if (maxa == mina) pulse = minp;
        else pulse = minp + ((a - mina) * (maxp - minp)) / (maxa - mina);
        if (pulse < 0) pulse = 0;
        if (pulse > 65535) pulse = 65535;
        pulse_counts[ln] = us_counts(pulse);
        return 1'b1;
    endfunction

    function automatic int find_slot(input int unsigned ln);
        for (int i = 0; i < table_used; i++)
            if (table_lines[i] == ln) return i;
        return -1;
    endfunction

    function automatic t_servo_result predict_item(input msps_pkg::t_action act,
            input logic [3:0] ln, input logic signed [15:0] ang);
        t_servo_result r;
        bit ok;
        int pos;
        ok = 1'b0;
        case (act)
            msps_pkg::ACT_TICK: begin
                if (tick_count == bank_compare[0]) service_bank(0);
                if (tick_count == bank_compare[1]) service_bank(1);
                tick_count = tick_count + 16'd1;
                ok = 1'b1;
            end
            msps_pkg::ACT_SET: begin
                ok = map_angle(ln, ang);
            end
            msps_pkg::ACT_ON: begin
                if (ln < msps_pkg::SERVO_SLOTS && table_used < msps_pkg::SERVO_SLOTS &&
                    find_slot(ln) < 0) begin
                    void'(map_angle(ln, ang));
                    table_lines[table_used] = ln;
                    table_used++;
                    ok = 1'b1;
                end
            end
            default: begin
                pos = (ln < msps_pkg::SERVO_SLOTS) ? find_slot(ln) : -1;
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < table_used; i++)
                        table_lines[i] = table_lines[i + 1];
                    table_used--;
                    ok = 1'b1;
                end
            end
        endcase
        r.levels   = line_levels;
        r.accepted = ok;
        r.count    = msps_pkg::USED_W'(table_used);
        return r;
    endfunction

    // result checker, config shadow and expectation capture
    always @(posedge i_clk) begin
        t_servo_result exp_r;
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("multiplexed_servo_pulse_sequencer_core test failed");
            $finish;
        end
        if (i_rst_n) begin
            if (o_done) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_line_levels !== exp_r.levels)
                        report_mismatch($sformatf("line_levels %h expected %h",
                            o_line_levels, exp_r.levels));
                    if (o_accepted !== exp_r.accepted)
                        report_mismatch($sformatf("accepted %b expected %b",
                            o_accepted, exp_r.accepted));
                    if (o_active_count !== exp_r.count)
                        report_mismatch($sformatf("active_count %0d expected %0d",
                            o_active_count, exp_r.count));
                end
            end
            if (i_cfg_we && i_cfg_idx < 6)
                cal_regs[i_cfg_idx] = i_cfg_wdata;
            if (i_start && !o_busy)
                pending_results.push_back(predict_item(msps_pkg::t_action'(i_action),
                    i_line_id, i_angle));
        end
    end

    // send one item, leaving start high after it is taken
    task automatic send_item(input msps_pkg::t_action act, input logic [3:0] ln,
            input logic signed [15:0] ang);
        int unsigned gap;
        gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_action  <= act;
        i_line_id <= ln;
        i_angle   <= ang;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    task automatic send_ticks(input int unsigned n);
        for (int i = 0; i < n; i++)
            send_item(msps_pkg::ACT_TICK, 4'($urandom), 16'($urandom));
    endtask

    // stop sending and let every outstanding item finish
    task automatic drain();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cal(input logic [msps_pkg::CFG_IDX_W-1:0] idx,
            input logic [15:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_all_cal(input logic [15:0] mina, maxa, umin, umax, minp, maxp);
        write_cal(msps_pkg::CFG_MIN_ANGLE, mina);
        write_cal(msps_pkg::CFG_MAX_ANGLE, maxa);
        write_cal(msps_pkg::CFG_USABLE_MIN, umin);
        write_cal(msps_pkg::CFG_USABLE_MAX, umax);
        write_cal(msps_pkg::CFG_MIN_PULSE, minp);
        write_cal(msps_pkg::CFG_MAX_PULSE, maxp);
    endtask

    function automatic logic [15:0] draw_angle();
        int sel;
        logic signed [15:0] lo, hi;
        sel = $urandom_range(0, 9);
        lo  = cal_regs[msps_pkg::CFG_USABLE_MIN];
        hi  = cal_regs[msps_pkg::CFG_USABLE_MAX];
        if (sel < 6 && lo <= hi) return 16'($signed(lo) + $urandom_range(0, hi - lo));
        if (sel == 6) return lo;
        if (sel == 7) return hi;
        return 16'($urandom);
    endfunction

    // reset defaults, limit checks and out of range lines
    task automatic test_defaults();
        send_ticks(3);
        send_item(msps_pkg::ACT_SET, 4'd0, 16'sd0);
        send_item(msps_pkg::ACT_SET, 4'd1, 16'sd180);
        send_item(msps_pkg::ACT_SET, 4'd2, 16'sd90);
        send_item(msps_pkg::ACT_SET, 4'd3, -16'sd1);
        send_item(msps_pkg::ACT_SET, 4'd4, 16'sd181);
        send_item(msps_pkg::ACT_SET, 4'd12, 16'sd10);
        send_item(msps_pkg::ACT_SET, 4'd15, -16'sd32768);
        send_item(msps_pkg::ACT_ON, 4'd15, 16'sd32767);
        send_item(msps_pkg::ACT_OFF, 4'd5, 16'sd0);
        send_item(msps_pkg::ACT_OFF, 4'd13, 16'sd0);
    endtask

    // fill the table, overflow it, duplicates, removal and compaction
    task automatic test_table();
        for (int i = 0; i < msps_pkg::SERVO_SLOTS; i++)
            send_item(msps_pkg::ACT_ON, 4'(11 - i), 16'(i * 15));
        send_item(msps_pkg::ACT_ON, 4'd3, 16'sd0);
        send_item(msps_pkg::ACT_OFF, 4'd6, 16'sd0);
        send_item(msps_pkg::ACT_ON, 4'd6, 16'sd0);
        send_item(msps_pkg::ACT_ON, 4'd6, 16'sd0);
        send_item(msps_pkg::ACT_OFF, 4'd11, 16'sd0);
        send_item(msps_pkg::ACT_OFF, 4'd11, 16'sd0);
        send_item(msps_pkg::ACT_OFF, 4'd6, 16'sd0);
        for (int i = 0; i < msps_pkg::SERVO_SLOTS; i++)
            send_item(msps_pkg::ACT_OFF, 4'(i), 16'sd0);
    endtask

    // short pulses so that both banks raise and lower lines within a burst of ticks
    task automatic test_pulse_train();
        write_all_cal(16'sd0, 16'sd180, 16'sd0, 16'sd180, 16'd0, 16'd20);
        for (int i = 0; i < 9; i++)
            send_item(msps_pkg::ACT_ON, 4'((i * 5) % 12), 16'(i * 20 + 5));
        no_idle = 1'b1;
        for (int i = 0; i < 250; i++) begin
            if (i % 100 == 50)
                send_item(msps_pkg::ACT_OFF, 4'($urandom_range(0, 11)), 16'sd0);
            else if (i % 100 == 80)
                send_item(msps_pkg::ACT_ON, 4'($urandom_range(0, 11)), draw_angle());
            else if (i % 29 == 0)
                send_item(msps_pkg::ACT_SET, 4'($urandom_range(0, 11)), draw_angle());
            else
                send_item(msps_pkg::ACT_TICK, 4'($urandom), 16'($urandom));
        end
        no_idle = 1'b0;
    endtask

    // extreme calibration: full span, saturation, equal and reversed angles
    task automatic test_cal_extremes();
        write_all_cal(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
        send_item(msps_pkg::ACT_SET, 4'd0, -16'sd32768);
        send_item(msps_pkg::ACT_SET, 4'd1, 16'sd32767);
        send_item(msps_pkg::ACT_SET, 4'd2, 16'sd0);
        write_all_cal(16'sd5, 16'sd5, 16'h8000, 16'h7FFF, 16'd40000, 16'd100);
        send_item(msps_pkg::ACT_SET, 4'd3, 16'sd5);
        send_item(msps_pkg::ACT_SET, 4'd3, 16'sd6);
        write_all_cal(16'sd100, 16'sd0, 16'sd0, 16'sd100, 16'd100, 16'd0);
        send_item(msps_pkg::ACT_SET, 4'd4, 16'sd50);
        write_all_cal(16'sd0, 16'sd100, 16'sd20, 16'sd40, 16'd65535, 16'd0);
        send_item(msps_pkg::ACT_SET, 4'd5, 16'sd10);
        send_item(msps_pkg::ACT_SET, 4'd5, 16'sd30);
        send_item(msps_pkg::ACT_ON, 4'd7, 16'sd90);
        send_item(msps_pkg::ACT_OFF, 4'd7, 16'sd0);
        write_cal(3'd6, 16'hFFFF);
        write_cal(3'd7, 16'h5555);
    endtask

    // a run of back to back ticks with very short pulses
    task automatic test_tick_run();
        write_all_cal(16'sd0, 16'sd180, 16'sd0, 16'sd180, 16'd1, 16'd8);
        for (int i = 0; i < 8; i++)
            send_item(msps_pkg::ACT_ON, 4'($urandom_range(0, 11)), draw_angle());
        no_idle = 1'b1;
        send_ticks(150);
        no_idle = 1'b0;
    endtask

    // random mix under several calibrations
    task automatic test_random_mix();
        int r;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 2)
                write_all_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
            else
                write_all_cal(16'(-$urandom_range(0, 90)), 16'($urandom_range(0, 200)),
                    16'(-$urandom_range(0, 90)), 16'($urandom_range(0, 200)),
                    16'($urandom_range(0, 10)), 16'($urandom_range(0, 30)));
            for (int i = 0; i < 150; i++) begin
                r = $urandom_range(0, 99);
                if (r < 75) send_item(msps_pkg::ACT_TICK, 4'($urandom), 16'($urandom));
                else if (r < 85) send_item(msps_pkg::ACT_SET, 4'($urandom), draw_angle());
                else if (r < 93) send_item(msps_pkg::ACT_ON, 4'($urandom), draw_angle());
                else send_item(msps_pkg::ACT_OFF, 4'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_action    <= '0;
        i_line_id   <= '0;
        i_angle     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        err_count    = 0;
        items_sent   = 0;
        results_seen = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_table();
        test_pulse_train();
        test_cal_extremes();
        test_tick_run();
        test_random_mix();
        drain();

        $display("sent %0d items (ticks, angle sets, activates, deactivates), checked %0d results",
            items_sent, results_seen);
        $display("covered table fill and compaction, pulse trains, tick runs, cal extremes");
        if (err_count == 0) begin
            $display("multiplexed_servo_pulse_sequencer_core test passed");
        end else begin
            $display("multiplexed_servo_pulse_sequencer_core test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/msps_pkg.sv
src/msps_front.sv
src/msps_back.sv
src/multiplexed_servo_pulse_sequencer_core.sv
src/msps_checker.sv
test/tb.sv
